[rtl/core/vlvs_pkg.sv]
// ============================================================================
// vlvs_pkg: shared types and helpers for the velocity-limited Verlet step
// Holds the operation codes, register indexes, the pipeline stage record and
// small arithmetic helpers on 21-bit Q8.12 vector components.
// ============================================================================
package vlvs_pkg;

    // Vector layout: three 21-bit two's complement components, x lowest.
    localparam int VEC_W  = 21;
    localparam int VECS_W = 3 * VEC_W;

    // Kick quotient bits kept before the velocity add saturates anyway.
    localparam int KQ_W = 22;

    // Relative limit ceiling, above any squared speed.
    localparam logic [43:0] LIMIT_CAP = 44'h800_0000_0000;

    // Component range.
    localparam logic [20:0] COMP_MAX = 21'h0F_FFFF;
    localparam logic [20:0] COMP_MIN = 21'h10_0000;

    // Operation codes carried in tuser.
    typedef enum logic [1:0] {
        OP_FIRST  = 2'd0,
        OP_SECOND = 2'd1,
        OP_LOAD   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // Configuration register indexes (byte address / 4).
    localparam logic [2:0] REG_TSF = 3'd0;
    localparam logic [2:0] REG_TSP = 3'd1;
    localparam logic [2:0] REG_VLS = 3'd2;
    localparam logic [2:0] REG_REL = 3'd3;
    localparam logic [2:0] REG_PPM = 3'd4;
    localparam logic [2:0] REG_GRP = 3'd5;

    // One pipeline stage record; each stage fills in the fields it owns.
    typedef struct packed {
        t_op               op;
        logic              active;
        logic              type_ok;
        logic [31:0]       mass_in;
        logic [31:0]       radius;
        logic [VECS_W-1:0] frc;
        logic [VECS_W-1:0] vel;
        logic [VECS_W-1:0] pos;
        logic [39:0]       den;
        logic [2:0]        fneg;
        logic [2:0][52:0]  num;
        logic [2:0]        ksat;
        logic [2:0][21:0]  kq;
        logic [63:0]       lim_a;
        logic [63:0]       lim_p1;
        logic [63:0]       lim_p2;
        logic [95:0]       lim_prod;
        logic [43:0]       bound;
        logic [2:0][20:0]  vc;
        logic [2:0][40:0]  sq;
        logic [42:0]       vsq;
        logic              limited;
        logic [31:0]       total;
        logic [42:0]       rem;
        logic [47:0]       quo;
        logic [47:0]       sq_n;
        logic [47:0]       sq_res;
        logic [2:0][52:0]  pp;
    } t_stage;

    // Magnitude of a 21-bit two's complement value, as 21 unsigned bits.
    function automatic logic [20:0] mag21(input logic [20:0] v);
        return v[20] ? (~v + 21'd1) : v;
    endfunction

    // Saturate a signed value onto the 21-bit component range.
    function automatic logic [20:0] clamp21(input logic signed [31:0] x);
        if (x > 32'sd1048575) begin
            return COMP_MAX;
        end
        if (x < -32'sd1048576) begin
            return COMP_MIN;
        end
        return x[20:0];
    endfunction

endpackage

[rtl/core/velocity_limited_verlet_step.sv]
// ============================================================================
// velocity_limited_verlet_step: Verlet half-step kick with a speed limit
// Kicks the velocity by (dtf/mass)*force, clips the speed to the limit,
// counts clipped particles and, on the first half step, moves the position.
// ============================================================================
//
//  Channel   Direction  Handshake                Payload
//  s_axis    in         tvalid/tready            tuser: operation, tdata: particle
//  m_axis    out        tvalid/tready            tdata: updated particle + count
//  apb       in/out     psel/penable/pready      six 32-bit registers at 4*i
//
//  One item enters per cycle while the output is not stalled.
//  The pipeline holds the kick divider (22 stages), the limit ratio
//  divider (48 stages) and the square root (24 stages), one bit per stage.
//  A stall at the output freezes the whole pipeline; nothing is lost.
//  Reset clears the valid bits and the limited counter and loads the register defaults.
//
module velocity_limited_verlet_step #(
    parameter int NUM_TYPES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Request side.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tuser: operation [1:0]
    input  logic [1:0]   s_axis_tuser,
    // tdata: particle_mask [31:0], particle_type [35:32], mass_value [67:36],
    // particle_radius [99:68], force_xyz [162:100], velocity_xyz [225:163],
    // position_xyz [288:226], zero fill [295:289]
    input  logic [295:0] s_axis_tdata,
    // Result side.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: new_velocity_xyz [62:0], new_position_xyz [125:63],
    // was_limited [126], limited_total [158:127], zero fill [159]
    output logic [159:0] m_axis_tdata,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import vlvs_pkg::*;

    localparam int TYPE_W    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int ST_MUL    = 1;
    localparam int ST_NUM    = 2;
    localparam int DIV_FIRST = 3;
    localparam int DIV_LAST  = DIV_FIRST + KQ_W - 1;
    localparam int ST_PROD   = DIV_FIRST;
    localparam int ST_BOUND  = DIV_FIRST + 1;
    localparam int ST_KICK   = DIV_LAST + 1;
    localparam int ST_SQ     = ST_KICK + 1;
    localparam int ST_SUM    = ST_SQ + 1;
    localparam int ST_CMP    = ST_SUM + 1;
    localparam int QD_FIRST  = ST_CMP + 1;
    localparam int QD_LAST   = QD_FIRST + 47;
    localparam int SQ_FIRST  = QD_LAST + 1;
    localparam int SQ_LAST   = SQ_FIRST + 23;
    localparam int ST_SCALE  = SQ_LAST + 1;
    localparam int ST_PMUL   = ST_SCALE + 1;
    localparam int ST_PADD   = ST_PMUL + 1;
    localparam int NUM_ST    = ST_PADD + 1;

    // Configuration registers.
    logic [31:0] r_tsf;
    logic [31:0] r_tsp;
    logic [31:0] r_vls;
    logic        r_rel;
    logic        r_ppm;
    logic [31:0] r_grp;
    logic        cfg_wr;

    // Pipeline.
    t_stage      r_st [NUM_ST];
    t_stage      n_st [NUM_ST];
    logic [NUM_ST-1:0] r_vld;
    logic        en;
    logic [31:0] r_count;

    // Type mass memory with registered read.
    logic [31:0] r_type_mass [NUM_TYPES];
    logic [31:0] r_tbl;
    logic [7:0]  in_type8;
    logic [TYPE_W-1:0] in_idx;
    logic        in_type_ok;
    t_op         in_op;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsf <= '0;
            r_tsp <= '0;
            r_vls <= '1;
            r_rel <= 1'b0;
            r_ppm <= 1'b0;
            r_grp <= 32'd1;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_TSF: r_tsf <= pwdata;
                REG_TSP: r_tsp <= pwdata;
                REG_VLS: r_vls <= pwdata;
                REG_REL: r_rel <= pwdata[0];
                REG_PPM: r_ppm <= pwdata[0];
                REG_GRP: r_grp <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (paddr[4:2])
            REG_TSF: prdata = r_tsf;
            REG_TSP: prdata = r_tsp;
            REG_VLS: prdata = r_vls;
            REG_REL: prdata = {31'd0, r_rel};
            REG_PPM: prdata = {31'd0, r_ppm};
            REG_GRP: prdata = r_grp;
            default: prdata = '0;
        endcase
    end

    // The whole pipeline advances unless a finished result is held.
    assign en            = !r_vld[NUM_ST-1] || m_axis_tready;
    assign s_axis_tready = en;

    assign in_op      = t_op'(s_axis_tuser);
    assign in_type8   = {4'd0, s_axis_tdata[35:32]};
    assign in_idx     = in_type8[TYPE_W-1:0];
    assign in_type_ok = {1'b0, in_type8} < 9'(NUM_TYPES);

    // Mass table: loads write at acceptance, every item reads its entry.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tbl <= r_type_mass[in_idx];
            if (s_axis_tvalid && in_op == OP_LOAD && in_type_ok) begin
                r_type_mass[in_idx] <= s_axis_tdata[67:36];
            end
        end
    end

    // Input stage: unpack the request.
    always_comb begin
        n_st[0]         = '0;
        n_st[0].op      = in_op;
        n_st[0].active  = (in_op == OP_FIRST || in_op == OP_SECOND)
                          && ((s_axis_tdata[31:0] & r_grp) != 32'd0);
        n_st[0].type_ok = in_type_ok;
        n_st[0].mass_in = s_axis_tdata[67:36];
        n_st[0].radius  = s_axis_tdata[99:68];
        n_st[0].frc     = s_axis_tdata[162:100];
        n_st[0].vel     = s_axis_tdata[225:163];
        n_st[0].pos     = s_axis_tdata[288:226];
    end

    // Stage logic, one block per register stage.
    for (genvar s = 1; s < NUM_ST; s++) begin : g_st
        localparam int KBIT = (s >= DIV_FIRST && s <= DIV_LAST) ? DIV_LAST - s : 0;
        localparam int SEXP = (s >= SQ_FIRST && s <= SQ_LAST) ?
                              46 - 2 * (s - SQ_FIRST) : 0;

        always_comb begin
            t_stage             c;
            logic [31:0]        mass;
            logic [61:0]        dsh;
            logic [20:0]        v;
            logic [20:0]        m;
            logic signed [23:0] vs;
            logic signed [23:0] sum;
            logic [43:0]        rem2;
            logic [48:0]        trial;
            logic [47:0]        nn;
            logic [47:0]        rr;
            logic [44:0]        smag;
            logic [52:0]        rnd;
            logic signed [31:0] xs;
            logic [62:0]        xpack;
            logic [62:0]        vpack;
            mass  = '0;
            dsh   = '0;
            v     = '0;
            m     = '0;
            vs    = '0;
            sum   = '0;
            rem2  = '0;
            trial = '0;
            nn    = '0;
            rr    = '0;
            smag  = '0;
            rnd   = '0;
            xs    = '0;
            xpack = '0;
            vpack = '0;
            c = r_st[s-1];

            // Mass select, force products and the relative limit product.
            if (s == ST_MUL) begin
                mass = r_ppm ? c.mass_in : (c.type_ok ? r_tbl : 32'd0);
                if (mass == 32'd0) begin
                    mass = 32'd1;
                end
                c.den = {mass, 8'd0};
                for (int k = 0; k < 3; k++) begin
                    v         = c.frc[VEC_W*k +: VEC_W];
                    c.fneg[k] = v[20];
                    c.num[k]  = 53'(r_tsf) * 53'(mag21(v));
                end
                c.lim_a = 64'(r_vls) * 64'(c.radius);
            end

            // Rounding offset, saturation check and radius partial products.
            if (s == ST_NUM) begin
                c.kq = '0;
                for (int k = 0; k < 3; k++) begin
                    c.num[k]  = c.num[k] + 53'(c.den[39:1]);
                    c.ksat[k] = {9'd0, c.num[k]} >= {c.den, 22'd0};
                end
                c.lim_p1 = 64'(c.lim_a[31:0]) * 64'(c.radius);
                c.lim_p2 = 64'(c.lim_a[63:32]) * 64'(c.radius);
            end

            if (s == ST_PROD) begin
                c.lim_prod = {c.lim_p2, 32'd0} + 96'(c.lim_p1);
            end

            // Limit in Q.24: absolute, or radius scaled and capped.
            if (s == ST_BOUND) begin
                if (r_rel && r_ppm) begin
                    c.bound = (c.lim_prod[95:24] > 72'(LIMIT_CAP)) ? LIMIT_CAP
                              : c.lim_prod[67:24];
                end else begin
                    c.bound = {4'd0, r_vls, 8'd0};
                end
            end

            // Kick divider, one quotient bit per stage.
            if (s >= DIV_FIRST && s <= DIV_LAST) begin
                dsh = 62'(c.den) << KBIT;
                for (int k = 0; k < 3; k++) begin
                    if ({9'd0, c.num[k]} >= dsh) begin
                        c.num[k]      = c.num[k] - dsh[52:0];
                        c.kq[k][KBIT] = 1'b1;
                    end
                end
            end

            // Velocity plus kick, saturated.
            if (s == ST_KICK) begin
                for (int k = 0; k < 3; k++) begin
                    v   = c.vel[VEC_W*k +: VEC_W];
                    vs  = {{3{v[20]}}, v};
                    sum = c.fneg[k] ? vs - $signed({2'd0, c.kq[k]})
                                    : vs + $signed({2'd0, c.kq[k]});
                    if (c.ksat[k]) begin
                        c.vc[k] = c.fneg[k] ? COMP_MIN : COMP_MAX;
                    end else begin
                        c.vc[k] = clamp21({{8{sum[23]}}, sum});
                    end
                end
            end

            if (s == ST_SQ) begin
                for (int k = 0; k < 3; k++) begin
                    m       = mag21(c.vc[k]);
                    c.sq[k] = 41'(m) * 41'(m);
                end
            end

            if (s == ST_SUM) begin
                c.vsq = 43'(c.sq[0]) + 43'(c.sq[1]) + 43'(c.sq[2]);
            end

            // Limit decision and the counter value this item reports.
            if (s == ST_CMP) begin
                c.limited = c.active && (44'(c.vsq) > c.bound);
                c.total   = (c.limited && r_count != '1) ? r_count + 32'd1 : r_count;
                c.rem     = c.bound[42:0];
                c.quo     = '0;
            end

            // Ratio divider: limit * 2^48 / vsq, one bit per stage.
            if (s >= QD_FIRST && s <= QD_LAST) begin
                rem2 = {c.rem, 1'b0};
                if (rem2 >= 44'(c.vsq)) begin
                    c.rem = 43'(rem2 - 44'(c.vsq));
                    c.quo = {c.quo[46:0], 1'b1};
                end else begin
                    c.rem = rem2[42:0];
                    c.quo = {c.quo[46:0], 1'b0};
                end
            end

            // Square root, one result bit per stage.
            if (s >= SQ_FIRST && s <= SQ_LAST) begin
                nn    = (s == SQ_FIRST) ? c.quo : c.sq_n;
                rr    = (s == SQ_FIRST) ? 48'd0 : c.sq_res;
                trial = 49'(rr) + (49'd1 << SEXP);
                if (49'(nn) >= trial) begin
                    nn = nn - trial[47:0];
                    rr = (rr >> 1) + (48'd1 << SEXP);
                end else begin
                    rr = rr >> 1;
                end
                c.sq_n   = nn;
                c.sq_res = rr;
            end

            // Scale the clipped velocity.
            if (s == ST_SCALE) begin
                if (c.limited) begin
                    for (int k = 0; k < 3; k++) begin
                        m       = mag21(c.vc[k]);
                        smag    = 45'(m) * 45'(c.sq_res[23:0]);
                        c.vc[k] = c.vc[k][20] ? (~smag[44:24] + 21'd1) : smag[44:24];
                    end
                end
            end

            if (s == ST_PMUL) begin
                for (int k = 0; k < 3; k++) begin
                    c.pp[k] = 53'(r_tsp) * 53'(mag21(c.vc[k]));
                end
            end

            // Position move and result assembly.
            if (s == ST_PADD) begin
                xpack = '0;
                vpack = '0;
                for (int k = 0; k < 3; k++) begin
                    rnd = c.pp[k] + 53'h80_0000;
                    v   = c.pos[VEC_W*k +: VEC_W];
                    xs  = {{11{v[20]}}, v};
                    xs  = c.vc[k][20] ? xs - $signed({3'd0, rnd[52:24]})
                                      : xs + $signed({3'd0, rnd[52:24]});
                    xpack[VEC_W*k +: VEC_W] = clamp21(xs);
                    vpack[VEC_W*k +: VEC_W] = c.vc[k];
                end
                if (c.active) begin
                    c.vel = vpack;
                    if (c.op == OP_FIRST) begin
                        c.pos = xpack;
                    end
                end
            end

            n_st[s] = c;
        end
    end

    // Stage registers and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_ST-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NUM_ST; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    // Limited counter, saturating.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (en && r_vld[ST_CMP-1]) begin
            r_count <= n_st[ST_CMP].total;
        end
    end

    assign m_axis_tvalid = r_vld[NUM_ST-1];
    assign m_axis_tdata  = {1'b0, r_st[NUM_ST-1].total, r_st[NUM_ST-1].limited,
                            r_st[NUM_ST-1].pos, r_st[NUM_ST-1].vel};

    // The counter never goes down.
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("limited counter decreased");

    // The counter moves only for a clipped item at the compare stage.
    a_count_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_count != $past(r_count)
        |-> $past(en && r_vld[ST_CMP-1] && n_st[ST_CMP].limited))
        else $error("counter changed without a clipped item");

    // A clipped result always reports a nonzero count.
    a_limited_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[126] |-> m_axis_tdata[158:127] != 32'd0)
        else $error("clipped result with zero count");

endmodule

[tb/sv/velocity_limited_verlet_step_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// velocity_limited_verlet_step_tb: self-checking bench for the Verlet step
// Sends directed and random particle requests with random gaps and output
// stalls. Each result is compared field by field against a typed-in row or an
// in-bench prediction of the kick, speed limit, position move and limited counter.
// The run walks several register settings, the extremes among them.
// ============================================================================
module velocity_limited_verlet_step_tb;
    import vlvs_pkg::*;

    localparam int LATENCY  = 104;
    localparam int WDOG_MAX = 20000;

    // Reset assertion length, in clock cycles.
    localparam int RESET_CYCLES = 9;

    // One particle request.
    typedef struct {
        t_op         op;
        logic [31:0] pmask;
        logic [3:0]  ptype;
        logic [31:0] mass;
        logic [31:0] radius;
        logic [62:0] frc;
        logic [62:0] vel;
        logic [62:0] pos;
    } t_particle;

    // One particle result.
    typedef struct {
        logic [62:0] vel;
        logic [62:0] pos;
        logic        limited;
        logic [31:0] total;
    } t_update;

    // One row of the directed table; chk set means a typed-in expectation.
    typedef struct {
        t_particle   p;
        logic        chk;
        t_update     exp_u;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // tuser: operation [1:0]
    logic [1:0]   s_axis_tuser;
    // tdata: particle_mask, particle_type, mass_value, particle_radius,
    // force_xyz, velocity_xyz, position_xyz, zero fill (lowest first)
    logic [295:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tdata: new_velocity_xyz, new_position_xyz, was_limited, limited_total,
    // zero fill (lowest first)
    logic [159:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    velocity_limited_verlet_step #(.NUM_TYPES(16)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor copy of the registers and state.
    logic [31:0] dtf_reg, dtv_reg, vlim_reg, grp_reg;
    logic        rel_reg, ppm_reg;
    logic [31:0] mass_tab [16];
    logic [31:0] clip_count;

    t_update     pending_updates [$];
    int          errors;
    int          n_results;
    int          n_clipped;
    int          wdog;
    bit          stall_on;

    always #2 i_clk = ~i_clk;

    // Helpers on 21-bit components.
    function automatic longint sx21(input logic [62:0] w, input int c);
        logic [20:0] b;
        b = w[21*c +: 21];
        return longint'(signed'(b));
    endfunction

    function automatic longint sat21(input longint x);
        if (x > 1048575) begin
            return 1048575;
        end
        if (x < -1048576) begin
            return -1048576;
        end
        return x;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Predict the result of one request and update the predictor state.
    function automatic t_update verlet_predict(input t_particle p);
        t_update     u;
        logic [63:0] m, d, n, k, vsq, bound, q, rem, sc, mg, pr, r;
        logic [127:0] wide;
        longint      vc [3];
        longint      x;
        u.vel = p.vel;
        u.pos = p.pos;
        u.limited = 1'b0;
        u.total = clip_count;
        if (p.op == OP_LOAD) begin
            mass_tab[p.ptype] = p.mass;
            return u;
        end
        if (p.op == OP_NOP || (p.pmask & grp_reg) == 0) begin
            return u;
        end
        m = ppm_reg ? {32'd0, p.mass} : {32'd0, mass_tab[p.ptype]};
        if (m == 0) begin
            m = 1;
        end
        d = m << 8;
        vsq = 0;
        for (int c = 0; c < 3; c++) begin
            x = sx21(p.frc, c);
            n = 64'(dtf_reg) * 64'(x < 0 ? -x : x);
            k = (n + d / 2) / d;
            vc[c] = sat21(sx21(p.vel, c) + (x < 0 ? -longint'(k) : longint'(k)));
            mg = 64'(vc[c] < 0 ? -vc[c] : vc[c]);
            vsq += mg * mg;
        end
        if (rel_reg && ppm_reg) begin
            wide = (128'(vlim_reg) * 128'(p.radius) * 128'(p.radius)) >> 24;
            bound = (wide > 128'(LIMIT_CAP)) ? 64'(LIMIT_CAP) : wide[63:0];
        end else begin
            bound = 64'(vlim_reg) << 8;
        end
        if (vsq > bound) begin
            wide = (128'(bound) << 48) / 128'(vsq);
            q = wide[63:0];
            sc = root64(q);
            for (int c = 0; c < 3; c++) begin
                mg = 64'(vc[c] < 0 ? -vc[c] : vc[c]);
                mg = (mg * sc) >> 24;
                vc[c] = vc[c] < 0 ? -longint'(mg) : longint'(mg);
            end
            if (clip_count != 32'hFFFF_FFFF) begin
                clip_count++;
            end
            u.limited = 1'b1;
            u.total = clip_count;
        end
        for (int c = 0; c < 3; c++) begin
            u.vel[21*c +: 21] = vc[c][20:0];
        end
        if (p.op == OP_FIRST) begin
            for (int c = 0; c < 3; c++) begin
                pr = 64'(dtv_reg) * 64'(vc[c] < 0 ? -vc[c] : vc[c]);
                r = (pr + (64'd1 << 23)) >> 24;
                x = sat21(sx21(p.pos, c) + (vc[c] < 0 ? -longint'(r) : longint'(r)));
                u.pos[21*c +: 21] = x[20:0];
            end
        end
        return u;
    endfunction

    // Register write over the configuration port, setup then access.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TSF: dtf_reg  = val;
            REG_TSP: dtv_reg  = val;
            REG_VLS: vlim_reg = val;
            REG_REL: rel_reg  = val[0];
            REG_PPM: ppm_reg  = val[0];
            REG_GRP: grp_reg  = val;
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [31:0] f, input logic [31:0] v,
                           input logic [31:0] l, input logic rl,
                           input logic pm, input logic [31:0] g);
        reg_write(REG_TSF, f);
        reg_write(REG_TSP, v);
        reg_write(REG_VLS, l);
        reg_write(REG_REL, {31'd0, rl});
        reg_write(REG_PPM, {31'd0, pm});
        reg_write(REG_GRP, g);
    endtask

    // Let the pipeline drain before touching the registers.
    task automatic drain;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // Present one request, with a random gap before it if gaps is set.
    task automatic send_particle(input t_particle p, input bit gaps);
        int gap;
        gap = 0;
        if (gaps) begin
            gap = ($urandom_range(0, 9) < 6) ? 0 :
                  (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                              : $urandom_range(8, 30));
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= p.op;
        s_axis_tdata  <= {7'd0, p.pos, p.vel, p.frc, p.radius, p.mass,
                          p.ptype, p.pmask};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_updates.push_back(verlet_predict(p));
    endtask

    task automatic idle_input;
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [62:0] rnd_vec(input int mode);
        logic [62:0] w;
        w = {$urandom, $urandom};
        // Mode 1 keeps components small so that limits bite less often.
        if (mode == 1) begin
            for (int c = 0; c < 3; c++) begin
                w[21*c +: 21] = 21'(signed'(12'($urandom)));
            end
        end
        return w;
    endfunction

    function automatic t_particle rnd_particle(input int fill);
        t_particle p;
        int        s;
        s = $urandom_range(0, 99);
        p.op = (s < 42) ? OP_FIRST : (s < 84) ? OP_SECOND : (s < 94) ? OP_LOAD : OP_NOP;
        p.pmask = ($urandom_range(0, 3) == 0) ? $urandom : (32'd1 << $urandom_range(0, 31));
        p.ptype = 4'($urandom_range(0, fill - 1));
        if (p.op == OP_LOAD) begin
            p.ptype = 4'($urandom);
        end
        p.mass = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom;
        if (p.op == OP_LOAD && p.mass == 0) begin
            p.mass = 1;
        end
        p.radius = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
        p.frc = rnd_vec($urandom_range(0, 1));
        p.vel = rnd_vec($urandom_range(0, 1));
        p.pos = rnd_vec(0);
        return p;
    endfunction

    // Result check against the oldest expectation, with random stalls.
    always @(posedge i_clk) begin
        t_update e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_updates.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    errors++;
                end else begin
                    e = pending_updates.pop_front();
                    n_results++;
                    if (m_axis_tdata[62:0] !== e.vel) begin
                        $error("new_velocity_xyz exp %h got %h", e.vel, m_axis_tdata[62:0]);
                        errors++;
                    end
                    if (m_axis_tdata[125:63] !== e.pos) begin
                        $error("new_position_xyz exp %h got %h", e.pos, m_axis_tdata[125:63]);
                        errors++;
                    end
                    if (m_axis_tdata[126] !== e.limited) begin
                        $error("was_limited exp %0d got %0d", e.limited, m_axis_tdata[126]);
                        errors++;
                    end
                    if (m_axis_tdata[158:127] !== e.total) begin
                        $error("limited_total exp %0d got %0d", e.total, m_axis_tdata[158:127]);
                        errors++;
                    end
                    if (e.limited) begin
                        n_clipped++;
                    end
                end
            end
            // Mostly short random stalls, now and then a long one.
            if (stall_on) begin
                if ($urandom_range(0, 19) == 0) begin
                    stall_on <= 1'b0;
                end
            end else if ($urandom_range(0, 199) == 0) begin
                stall_on <= 1'b1;
            end
            m_axis_tready <= stall_on ? 1'b0 : ($urandom_range(0, 9) < 7);
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            wdog <= 0;
        end else if (i_rst_n && (pending_updates.size() != 0 || s_axis_tvalid)) begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("timeout with %0d results outstanding", pending_updates.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Stimulus.
    initial begin
        t_row      rows [$];
        t_row      rw;
        t_particle p;
        t_update   u;
        int        fill;
        int        phase;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = OP_FIRST;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        n_results = 0;
        n_clipped = 0;
        wdog = 0;
        stall_on = 1'b0;
        dtf_reg = 0;
        dtv_reg = 0;
        vlim_reg = 32'hFFFF_FFFF;
        rel_reg = 0;
        ppm_reg = 0;
        grp_reg = 1;
        clip_count = 0;
        for (int i = 0; i < 16; i++) begin
            mass_tab[i] = 0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Reset registers: zero time steps echo the velocity.
        p = '{OP_LOAD, 32'd1, 4'd0, 32'h0001_0000, 32'd0, 63'd0, 63'd0, 63'd0};
        u = '{63'd0, 63'd0, 1'b0, 32'd0};
        rows.push_back('{p, 1'b1, u});
        p = '{OP_LOAD, 32'd0, 4'd15, 32'hFFFF_FFFF, 32'd0, 63'h7FFF_FFFF_FFFF_FFFF,
              63'h1234_5678_9ABC_DEF0, 63'h7FFF_FFFF_FFFF_FFFF};
        u = '{63'h1234_5678_9ABC_DEF0, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0, 32'd0};
        rows.push_back('{p, 1'b1, u});
        // Small speed, well under the reset limit: echoes.
        p = '{OP_FIRST, 32'd1, 4'd0, 32'd0, 32'd0, 63'h7FFF_FFFF_FFFF_FFFF,
              63'h0000_0000_0001_2345, 63'h0FED_CBA9_8765_4321};
        u = '{63'h0000_0000_0001_2345, 63'h0FED_CBA9_8765_4321, 1'b0, 32'd0};
        rows.push_back('{p, 1'b1, u});
        // Outside the group: echoes.
        p = '{OP_SECOND, 32'hFFFF_FFFE, 4'd0, 32'd5, 32'd0, 63'h7FFF_FFFF_FFFF_FFFF,
              63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA};
        u = '{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 32'd0};
        rows.push_back('{p, 1'b1, u});
        // No-operation code: echoes.
        p = '{OP_NOP, 32'hFFFF_FFFF, 4'd15, 32'd7, 32'd9, 63'h1, 63'h7FFF_0000_0000_FFFF,
              63'h4000_0000_0000_0001};
        u = '{63'h7FFF_0000_0000_FFFF, 63'h4000_0000_0000_0001, 1'b0, 32'd0};
        rows.push_back('{p, 1'b1, u});
        foreach (rows[i]) begin
            send_particle(rows[i].p, 1'b0);
            if (rows[i].chk) begin
                u = pending_updates.pop_back();
                pending_updates.push_back(rows[i].exp_u);
            end
        end
        idle_input();
        drain();

        // Predicted rows with extreme registers and every type loaded.
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        rows.delete();
        for (int t = 0; t < 16; t++) begin
            p = '{OP_LOAD, 32'd0, 4'(t), (t == 3) ? 32'd1 : 32'h0001_0000 << (t % 8),
                  32'd0, 63'd0, 63'd0, 63'd0};
            send_particle(p, 1'b0);
        end
        for (int i = 0; i < 6; i++) begin
            p.op = (i % 2) ? OP_SECOND : OP_FIRST;
            p.pmask = 32'h8000_0000;
            p.ptype = 4'(i);
            p.mass = 32'd0;
            p.radius = 32'hFFFF_FFFF;
            p.frc = (i < 3) ? {3{21'h0F_FFFF}} : {3{21'h10_0000}};
            p.vel = (i % 3 == 0) ? {3{21'h10_0000}} : {3{21'h0F_FFFF}};
            p.pos = (i < 2) ? {3{21'h0F_FFFF}} : {3{21'h10_0000}};
            send_particle(p, 1'b0);
        end
        idle_input();
        drain();

        // Random phases across settings, extremes included.
        fill = 16;
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_all(32'h0100_0000, 32'h0100_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h1);
                1: set_all(32'h0040_0000, 32'h0080_0000, 32'h0000_4000, 1'b0, 1'b1, 32'hFFFF_FFFF);
                2: set_all(32'h0200_0000, 32'h0010_0000, 32'h0001_0000, 1'b1, 1'b1, 32'hF0F0_F0F0);
                3: set_all($urandom, $urandom, $urandom, 1'b1, 1'b0, $urandom);
                4: set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1, 32'hFFFF_FFFF);
                5: set_all(32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0);
                default: set_all($urandom, $urandom, $urandom_range(0, 32'h0010_0000),
                                 1'($urandom), 1'($urandom), $urandom);
            endcase
            for (int i = 0; i < 100; i++) begin
                send_particle(rnd_particle(fill), 1'b1);
            end
            idle_input();
            drain();
        end

        $display("Covered %0d results, %0d of them speed-limited, over seven settings.",
                 n_results, n_clipped);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
